FILE: hdl/tsq_pkg.sv
// shared types and constants of the tone sequencer
package tsq_pkg;

	localparam int OP_W       = 3;
	localparam int SLOT_W     = 6;
	localparam int HZ_W       = 16;
	localparam int LEN_W      = 16;
	localparam int SECS_W     = 16;
	localparam int POS_W      = 6;
	localparam int ELAPSED_W  = 17;
	localparam int TEMPO_W    = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 3'd0,
		OP_LOAD   = 3'd1,
		OP_START  = 3'd2,
		OP_STOP   = 3'd3,
		OP_EFFECT = 3'd4,
		OP_TIME   = 3'd5
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 1'b1;

	typedef enum logic [1:0] {
		TONE_KEEP,
		TONE_ZERO,
		TONE_MEM,
		TONE_EFFECT
	} tone_src_t;

	typedef struct packed {
		logic      capture;
		logic      tick_pre;
		logic      mul;
		logic      step;
		logic      halt;
		logic      start;
		logic      effect;
		logic      load;
		logic      tempo;
		logic      out_load;
		tone_src_t tone_src;
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            playing;
		logic            effect_active;
		logic            effect_ended;
		logic            hz_nonzero;
		logic            advance;
		logic            at_end;
		logic            loop_en;
	} dp_status_t;

endpackage

FILE: hdl/tsq_event_if.sv
// event channel carrying one sequencer command
interface tsq_event_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [5:0]  note_slot;
	logic [15:0] tone_hz;
	logic [15:0] length_ms;
	logic [15:0] seconds_left;

	modport source (
		output valid, op, note_slot, tone_hz, length_ms, seconds_left,
		input  ready
	);
	modport sink (
		input  valid, op, note_slot, tone_hz, length_ms, seconds_left,
		output ready
	);
endinterface

FILE: hdl/tsq_result_if.sv
// result channel carrying the sound state after each command
interface tsq_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] sound_hz;
	logic        music_on;
	logic        effect_on;
	logic [5:0]  note_position;

	modport source (
		output valid, sound_hz, music_on, effect_on, note_position,
		input  ready
	);
	modport sink (
		input  valid, sound_hz, music_on, effect_on, note_position,
		output ready
	);
endinterface

FILE: hdl/tsq_datapath.sv
// sequencer datapath: note memory, music and effect state, duration compare
module tsq_datapath #(
	parameter int NOTE_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tsq_pkg::dp_cmd_t                cmd,
	output tsq_pkg::dp_status_t             status,
	input  logic [tsq_pkg::OP_W-1:0]        op,
	input  logic [tsq_pkg::SLOT_W-1:0]      note_slot,
	input  logic [tsq_pkg::HZ_W-1:0]        tone_hz,
	input  logic [tsq_pkg::LEN_W-1:0]       length_ms,
	input  logic [tsq_pkg::SECS_W-1:0]      seconds_left,
	input  logic                            cfg_we,
	input  logic [tsq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsq_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic [tsq_pkg::HZ_W-1:0]        sound_hz,
	output logic                            music_on,
	output logic                            effect_on,
	output logic [tsq_pkg::POS_W-1:0]       note_position
);
	import tsq_pkg::*;

	localparam int ADDR_W    = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
	localparam int LEN_LIMIT = (NOTE_DEPTH < 64) ? NOTE_DEPTH : 64;
	localparam int EXT_W     = 16;
	localparam int SPAN_X_W  = LEN_W + 7;
	localparam int ELAP_X_W  = ELAPSED_W + 1 + TEMPO_W + 1;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
	localparam logic [CFG_DATA_W-1:0] LEN_LIMIT_V = CFG_DATA_W'(LEN_LIMIT);

	logic [OP_W-1:0]       op_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [HZ_W-1:0]       hz_q;
	logic [LEN_W-1:0]      len_q;
	logic [SECS_W-1:0]     secs_q;

	logic                  playing_q;
	logic [POS_W-1:0]      pos_q;
	logic [ELAPSED_W-1:0]  elapsed_q;
	logic                  eff_active_q;
	logic [LEN_W-1:0]      eff_left_q;
	logic                  ended_q;
	logic [TEMPO_W-1:0]    tempo_q;
	logic [HZ_W-1:0]       tone_q;
	logic [CFG_DATA_W-1:0] track_len_q;
	logic                  loop_q;

	logic [HZ_W-1:0]       pitch_mem [NOTE_DEPTH];
	logic [LEN_W-1:0]      span_mem  [NOTE_DEPTH];
	logic [HZ_W-1:0]       pitch_rd_q;
	logic [LEN_W-1:0]      span_rd_q;

	logic [SPAN_X_W-1:0]   span_x_q;
	logic [ELAP_X_W-1:0]   elap_x_q;

	logic [EXT_W-1:0]      pos_ext;
	logic [EXT_W-1:0]      slot_ext;
	logic [ADDR_W-1:0]     raddr;
	logic [ADDR_W-1:0]     waddr;
	logic                  slot_ok;
	logic [CFG_DATA_W-1:0] act_len;
	logic [CFG_DATA_W-1:0] next_pos;
	logic [LEN_W-1:0]      left_nxt;

	function automatic logic [TEMPO_W-1:0] tempo_for(input logic [SECS_W-1:0] secs);
		logic [TEMPO_W-1:0] t;
		if (secs == '0 || secs >= SECS_W'(30))
			t = TEMPO_W'(100);
		else if (secs >= SECS_W'(20))
			t = TEMPO_W'(110);
		else if (secs >= SECS_W'(10))
			t = TEMPO_W'(125);
		else if (secs >= SECS_W'(5))
			t = TEMPO_W'(150);
		else
			t = TEMPO_W'(200);
		return t;
	endfunction

	assign pos_ext  = EXT_W'(pos_q);
	assign slot_ext = EXT_W'(slot_q);
	assign raddr    = pos_ext[ADDR_W-1:0];
	assign waddr    = slot_ext[ADDR_W-1:0];
	assign slot_ok  = slot_ext < EXT_W'(NOTE_DEPTH);

	always_comb begin
		if (track_len_q == '0)
			act_len = CFG_DATA_W'(1);
		else if (track_len_q > LEN_LIMIT_V)
			act_len = LEN_LIMIT_V;
		else
			act_len = track_len_q;
	end

	assign next_pos = CFG_DATA_W'(pos_q) + CFG_DATA_W'(1);
	assign left_nxt = (eff_left_q != '0) ? eff_left_q - LEN_W'(1) : '0;

	assign status.op            = op_q;
	assign status.playing       = playing_q;
	assign status.effect_active = eff_active_q;
	assign status.effect_ended  = ended_q;
	assign status.hz_nonzero    = hz_q != '0;
	assign status.advance       = ELAP_X_W'(span_x_q) < elap_x_q;
	assign status.at_end        = next_pos >= act_len;
	assign status.loop_en       = loop_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			slot_q <= note_slot;
			hz_q   <= tone_hz;
			len_q  <= length_ms;
			secs_q <= seconds_left;
		end
	end

	// note memory, read port follows the current note
	always_ff @(posedge clk) begin
		if (cmd.load && slot_ok) begin
			pitch_mem[waddr] <= hz_q;
			span_mem[waddr]  <= len_q;
		end
		pitch_rd_q <= pitch_mem[raddr];
		span_rd_q  <= span_mem[raddr];
	end

	// scaled duration compare: elapsed >= floor(span*100/tempo) iff span*100 < (elapsed+1)*tempo
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			span_x_q <= SPAN_X_W'(span_rd_q) * SPAN_X_W'(100);
			elap_x_q <= (ELAP_X_W'(elapsed_q) + ELAP_X_W'(1)) * ELAP_X_W'(tempo_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q    <= 1'b0;
			pos_q        <= '0;
			elapsed_q    <= '0;
			eff_active_q <= 1'b0;
			eff_left_q   <= '0;
			ended_q      <= 1'b0;
			tempo_q      <= TEMPO_W'(100);
			tone_q       <= '0;
		end else begin
			if (cmd.halt) begin
				playing_q <= 1'b0;
				pos_q     <= '0;
				elapsed_q <= '0;
			end else if (cmd.start) begin
				playing_q <= 1'b1;
				pos_q     <= '0;
				elapsed_q <= '0;
			end else if (cmd.step) begin
				pos_q     <= status.at_end ? '0 : next_pos[POS_W-1:0];
				elapsed_q <= '0;
			end else if (cmd.tick_pre) begin
				if (playing_q && elapsed_q != ELAPSED_MAX)
					elapsed_q <= elapsed_q + ELAPSED_W'(1);
			end
			if (cmd.tick_pre) begin
				if (eff_active_q) begin
					eff_left_q <= left_nxt;
					ended_q    <= left_nxt == '0;
					if (left_nxt == '0)
						eff_active_q <= 1'b0;
				end else begin
					ended_q <= 1'b0;
				end
			end else if (cmd.effect) begin
				eff_active_q <= 1'b1;
				eff_left_q   <= len_q;
			end
			if (cmd.tempo)
				tempo_q <= tempo_for(secs_q);
			case (cmd.tone_src)
				TONE_KEEP:   tone_q <= tone_q;
				TONE_ZERO:   tone_q <= '0;
				TONE_MEM:    tone_q <= pitch_rd_q;
				TONE_EFFECT: tone_q <= hz_q;
				default:     tone_q <= tone_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_len_q <= CFG_DATA_W'(1);
			loop_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TRACK_LENGTH: track_len_q <= cfg_data;
				CFG_LOOP_ENABLE:  loop_q      <= cfg_data[0];
				default:          loop_q      <= loop_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sound_hz      <= tone_q;
			music_on      <= playing_q;
			effect_on     <= eff_active_q;
			note_position <= pos_q;
		end
	end

endmodule

FILE: hdl/tsq_ctrl.sv
// sequencer controller: command sequencing and result register handshake
module tsq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output tsq_pkg::dp_cmd_t    cmd,
	input  tsq_pkg::dp_status_t status
);
	import tsq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_CMP,
		ST_WAIT,
		ST_TONE,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid)
					state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				state_nxt = ST_DONE;
				case (status.op)
					OP_TICK: begin
						cmd.tick_pre = 1'b1;
						state_nxt    = ST_MUL;
					end
					OP_LOAD: cmd.load = 1'b1;
					OP_START: begin
						cmd.start = 1'b1;
						if (!status.effect_active)
							state_nxt = ST_WAIT;
					end
					OP_STOP: begin
						cmd.halt = 1'b1;
						if (!status.effect_active)
							cmd.tone_src = TONE_ZERO;
					end
					OP_EFFECT: begin
						if (status.hz_nonzero) begin
							cmd.effect   = 1'b1;
							cmd.tone_src = TONE_EFFECT;
						end
					end
					OP_TIME: cmd.tempo = 1'b1;
					default: state_nxt = ST_DONE;
				endcase
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				if (status.effect_ended && status.playing)
					cmd.tone_src = TONE_MEM;
				else if (!status.effect_active && !status.playing)
					cmd.tone_src = TONE_ZERO;
				if (status.effect_active || !status.playing)
					state_nxt = ST_DONE;
				else
					state_nxt = ST_CMP;
			end
			ST_CMP: begin
				state_nxt = ST_DONE;
				if (status.advance) begin
					if (status.at_end && !status.loop_en) begin
						cmd.halt     = 1'b1;
						cmd.tone_src = TONE_ZERO;
					end else begin
						cmd.step  = 1'b1;
						state_nxt = ST_WAIT;
					end
				end
			end
			ST_WAIT: state_nxt = ST_TONE;
			ST_TONE: begin
				cmd.tone_src = TONE_MEM;
				state_nxt    = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hdl/tone_sequencer_with_effect_override_core.sv
// top level of the tone sequencer with effect override
// Plays a note table loaded through load-note commands, one tick command per millisecond, and
// returns one result per command with the tone, play and effect flags and the note index. A
// tick runs execute and multiply, then compare while music plays with no effect, then a read
// wait and tone load when the note advances; start runs the wait and tone load unless an effect
// sounds, other commands only execute. The steps are set by the single registered read port
// of the note memory, which must be refetched after the position moves, and by the registered
// multiply that compares elapsed time against the tempo-scaled note duration. A new command
// is taken once the previous result is in the output register, even if it has not yet been
// collected. The note memory has no reset; entries must be loaded before they are played.
module tone_sequencer_with_effect_override_core #(
	parameter int NOTE_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tsq_event_if.sink                       events,
	tsq_result_if.source                    result,
	input  logic                            cfg_we,
	input  logic [tsq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsq_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tsq_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	tsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (events.valid),
		.in_ready  (events.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.status    (status)
	);

	tsq_datapath #(
		.NOTE_DEPTH (NOTE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.op            (events.op),
		.note_slot     (events.note_slot),
		.tone_hz       (events.tone_hz),
		.length_ms     (events.length_ms),
		.seconds_left  (events.seconds_left),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sound_hz      (result.sound_hz),
		.music_on      (result.music_on),
		.effect_on     (result.effect_on),
		.note_position (result.note_position)
	);

	// busy after each transfer in
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(events.valid && events.ready) |=> !events.ready)
		else $error("input taken again straight after a transfer");

	// stopped track sits at note zero
	a_stopped_position: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.music_on) |-> (result.note_position == '0))
		else $error("note position nonzero while stopped");

	// silence when neither music nor effect plays
	a_silence: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.music_on && !result.effect_on) |-> (result.sound_hz == '0))
		else $error("tone present with nothing playing");

endmodule

FILE: tb/tsq_sound_checker.sv
// checker that predicts and compares the sound state after every sequencer command
`timescale 1ns / 1ps

module tsq_sound_checker #(
	parameter int NOTE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tsq_event_if                           events,
	tsq_result_if                          result,
	input  logic                           cfg_we,
	input  logic [tsq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsq_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             failures,
	output int                             pending
);
	import tsq_pkg::*;

	localparam int REPORT_LIMIT = 10;
	localparam int POS_LIMIT    = 1 << POS_W;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	typedef struct packed {
		logic [HZ_W-1:0]  hz;
		logic             music;
		logic             effect;
		logic [POS_W-1:0] pos;
	} sound_state_t;

	sound_state_t expected_sound[$];

	logic [HZ_W-1:0]      pitch_mem [NOTE_DEPTH];
	logic [LEN_W-1:0]     span_mem [NOTE_DEPTH];
	logic                 running;
	logic [POS_W-1:0]     pos;
	logic [ELAPSED_W-1:0] elapsed;
	logic                 fx_on;
	logic [HZ_W-1:0]      fx_hz;
	logic [LEN_W-1:0]     fx_left;
	logic [TEMPO_W-1:0]   tempo;
	logic [HZ_W-1:0]      tone;
	logic [CFG_DATA_W-1:0] cfg_len;
	logic                 cfg_loop;

	function automatic int unsigned track_notes();
		int unsigned n;
		n = 32'(cfg_len);
		if (n < 1) n = 1;
		if (n > NOTE_DEPTH) n = NOTE_DEPTH;
		if (n > POS_LIMIT) n = POS_LIMIT;
		return n;
	endfunction

	function automatic logic [TEMPO_W-1:0] tempo_for_time(input logic [SECS_W-1:0] secs);
		if (secs == 0 || secs >= 30) return 8'd100;
		if (secs >= 20) return 8'd110;
		if (secs >= 10) return 8'd125;
		if (secs >= 5) return 8'd150;
		return 8'd200;
	endfunction

	task automatic halt_music();
		running = 1'b0;
		pos = '0;
		elapsed = '0;
		if (!fx_on) tone = '0;
	endtask

	task automatic play_tick();
		int unsigned limit;
		int unsigned nxt;
		if (running && elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
		if (fx_on) begin
			if (fx_left != 0) fx_left = fx_left - 1'b1;
			if (fx_left == 0) begin
				fx_on = 1'b0;
				tone = running ? pitch_mem[pos] : '0;
			end
		end
		if (fx_on) return;
		if (!running) begin
			tone = '0;
			return;
		end
		limit = (int'(span_mem[pos]) * 100) / int'(tempo);
		if (elapsed < limit) return;
		nxt = pos + 1;
		if (nxt >= track_notes()) begin
			if (cfg_loop) begin
				nxt = 0;
			end else begin
				halt_music();
				return;
			end
		end
		pos = POS_W'(nxt);
		elapsed = '0;
		tone = pitch_mem[pos];
	endtask

	task automatic apply_command(
		input logic [OP_W-1:0]   op,
		input logic [SLOT_W-1:0] slot,
		input logic [HZ_W-1:0]   hz,
		input logic [LEN_W-1:0]  len,
		input logic [SECS_W-1:0] secs
	);
		sound_state_t after;
		case (op)
			OP_TICK: play_tick();
			OP_LOAD: begin
				if (slot < NOTE_DEPTH) begin
					pitch_mem[slot] = hz;
					span_mem[slot] = len;
				end
			end
			OP_START: begin
				running = 1'b1;
				pos = '0;
				elapsed = '0;
				if (!fx_on) tone = pitch_mem[0];
			end
			OP_STOP: halt_music();
			OP_EFFECT: begin
				if (hz != 0) begin
					fx_on = 1'b1;
					fx_hz = hz;
					fx_left = len;
					tone = fx_hz;
				end
			end
			OP_TIME: tempo = tempo_for_time(secs);
			default: ;
		endcase
		after.hz = tone;
		after.music = running;
		after.effect = fx_on;
		after.pos = pos;
		expected_sound.push_back(after);
	endtask

	task automatic report(input string what, input sound_state_t want, input sound_state_t got);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display("%0t %s: expected hz %0d music %0b effect %0b pos %0d",
				$realtime, what, want.hz, want.music, want.effect, want.pos,
				", got hz %0d music %0b effect %0b pos %0d",
				got.hz, got.music, got.effect, got.pos);
	endtask

	task automatic compare_sound(input sound_state_t got);
		sound_state_t want;
		if (expected_sound.size() == 0) begin
			report("result with nothing expected", '0, got);
			return;
		end
		want = expected_sound.pop_front();
		if (got.hz !== want.hz || got.music !== want.music ||
				got.effect !== want.effect || got.pos !== want.pos)
			report("mismatch", want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		sound_state_t got;
		if (!arst_n) begin
			expected_sound.delete();
			running = 1'b0;
			pos = '0;
			elapsed = '0;
			fx_on = 1'b0;
			fx_hz = '0;
			fx_left = '0;
			tempo = 8'd100;
			tone = '0;
			cfg_len = 7'd1;
			cfg_loop = 1'b0;
			failures = 0;
			pending <= 0;
		end else begin
			if (result.valid && result.ready) begin
				got.hz = result.sound_hz;
				got.music = result.music_on;
				got.effect = result.effect_on;
				got.pos = result.note_position;
				compare_sound(got);
			end
			if (cfg_we) begin
				if (cfg_index == CFG_TRACK_LENGTH) cfg_len = cfg_data;
				else if (cfg_index == CFG_LOOP_ENABLE) cfg_loop = cfg_data[0];
			end
			if (events.valid && events.ready)
				apply_command(events.op, events.note_slot, events.tone_hz, events.length_ms,
					events.seconds_left);
			pending <= expected_sound.size();
		end
	end

endmodule

FILE: tb/tone_sequencer_with_effect_override_core_test.sv
// top of the tone sequencer testbench: clock, reset, command stimulus and verdict
`timescale 1ns / 1ps

module tone_sequencer_with_effect_override_core_test;
	import tsq_pkg::*;

	localparam int NOTE_DEPTH     = 64;
	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 110;
	localparam int HOLD_PHASE     = 4;
	localparam int PAUSE_PHASE    = 2;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int failures;
	int pending;
	int src_idle_pct = 25;
	int sink_idle_pct = 52;
	bit hold_request = 1'b0;
	int quiet_cycles = 0;

	tsq_event_if events();
	tsq_result_if result();

	tone_sequencer_with_effect_override_core #(.NOTE_DEPTH(NOTE_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.events    (events),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tsq_sound_checker #(.NOTE_DEPTH(NOTE_DEPTH)) sound_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.events    (events),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.failures  (failures),
		.pending   (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((events.valid && events.ready) || (result.valid && result.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side: random back-pressure, with one long hold-off on request
	initial begin
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			result.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic send_item(
		input logic [OP_W-1:0]   op,
		input logic [SLOT_W-1:0] slot,
		input logic [HZ_W-1:0]   hz,
		input logic [LEN_W-1:0]  len,
		input logic [SECS_W-1:0] secs
	);
		while ($urandom_range(99) < src_idle_pct) begin
			events.valid <= 1'b0;
			@(negedge clk);
		end
		events.valid <= 1'b1;
		events.op <= op;
		events.note_slot <= slot;
		events.tone_hz <= hz;
		events.length_ms <= len;
		events.seconds_left <= secs;
		@(posedge clk);
		while (!events.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		events.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic reconfigure(input logic [CFG_DATA_W-1:0] len, input logic loop_on);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(CFG_TRACK_LENGTH, len);
		write_reg(CFG_LOOP_ENABLE, {{(CFG_DATA_W-1){1'b0}}, loop_on});
	endtask

	// mostly ticks with short notes so tracks advance, wrap and stop; some noise
	task automatic send_random_run(input int count);
		int done_items;
		int unsigned pick;
		logic [OP_W-1:0]   op;
		logic [SLOT_W-1:0] slot;
		logic [HZ_W-1:0]   hz;
		logic [LEN_W-1:0]  len;
		logic [SECS_W-1:0] secs;
		done_items = 0;
		while (done_items < count) begin
			pick = $urandom_range(99);
			slot = SLOT_W'($urandom);
			hz = HZ_W'($urandom);
			len = ($urandom_range(31) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(6));
			secs = ($urandom_range(3) == 0) ? SECS_W'($urandom) : SECS_W'($urandom_range(35));
			if (pick < 56) op = OP_TICK;
			else if (pick < 68) op = OP_LOAD;
			else if (pick < 73) op = OP_START;
			else if (pick < 77) op = OP_STOP;
			else if (pick < 88) begin
				op = OP_EFFECT;
				if ($urandom_range(7) == 0) hz = '0;
			end
			else if (pick < 97) op = OP_TIME;
			else op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
			send_item(op, slot, hz, len, secs);
			if (!(op == OP_SPARE_LO || op == OP_SPARE_HI || (op == OP_EFFECT && hz == '0)))
				done_items++;
		end
	endtask

	logic [CFG_DATA_W-1:0] phase_len [PHASES] = '{7'd64, 7'd0, 7'd127, 7'd3, 7'd1, 7'd17};
	logic                  phase_loop [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

	initial begin
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		events.valid = 1'b0;
		events.op = '0;
		events.note_slot = '0;
		events.tone_hz = '0;
		events.length_ms = '0;
		events.seconds_left = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_reg(CFG_TRACK_LENGTH, 7'd2);
		write_reg(CFG_LOOP_ENABLE, 7'd0);

		// directed: tempo bands, zero spans, short and replaced effects, unused codes
		send_item(OP_TIME, '0, '0, '0, 16'd0);
		send_item(OP_TICK, '0, '0, '0, '0);
		send_item(OP_LOAD, 6'd0, 16'hFFFF, 16'd0, '0);
		send_item(OP_LOAD, 6'd1, 16'd0, 16'd2, '0);
		send_item(OP_LOAD, 6'd63, 16'd1, 16'hFFFF, '0);
		send_item(OP_START, '0, '0, '0, '0);
		send_item(OP_TICK, '0, '0, '0, '0);
		send_item(OP_TIME, '0, '0, '0, 16'hFFFF);
		send_item(OP_TIME, '0, '0, '0, 16'd29);
		send_item(OP_TIME, '0, '0, '0, 16'd20);
		send_item(OP_TIME, '0, '0, '0, 16'd19);
		send_item(OP_TIME, '0, '0, '0, 16'd10);
		send_item(OP_TIME, '0, '0, '0, 16'd9);
		send_item(OP_TIME, '0, '0, '0, 16'd5);
		send_item(OP_TIME, '0, '0, '0, 16'd4);
		send_item(OP_TICK, '0, '0, '0, '0);
		send_item(OP_EFFECT, '0, 16'd0, 16'd5, '0);
		send_item(OP_EFFECT, '0, 16'h8001, 16'd0, '0);
		send_item(OP_START, '0, '0, '0, '0);
		send_item(OP_TICK, '0, '0, '0, '0);
		send_item(OP_EFFECT, '0, 16'd7, 16'd2, '0);
		send_item(OP_EFFECT, '0, 16'd300, 16'd1, '0);
		send_item(OP_STOP, '0, '0, '0, '0);
		send_item(OP_TICK, '0, '0, '0, '0);
		send_item(OP_TICK, '0, '0, '0, '0);
		send_item(OP_SPARE_LO, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(OP_SPARE_HI, '0, '0, '0, '0);

		// fill the whole note table so any track length is safe to play
		for (int slot = 0; slot < NOTE_DEPTH; slot++)
			send_item(OP_LOAD, SLOT_W'(slot), HZ_W'($urandom), LEN_W'($urandom_range(4)),
				SECS_W'($urandom));

		for (int phase = 0; phase < PHASES; phase++) begin
			reconfigure(phase_len[phase], phase_loop[phase]);
			if (phase < 2) begin
				src_idle_pct = 25;
				sink_idle_pct = 52;
			end else if (phase < 4) begin
				src_idle_pct = 52;
				sink_idle_pct = 25;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			if (phase == HOLD_PHASE) hold_request = 1'b1;
			send_random_run(PHASE_ITEMS / 2);
			if (phase == PAUSE_PHASE) wait_drained();
			send_random_run(PHASE_ITEMS - PHASE_ITEMS / 2);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (failures == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
